/* hdl/pmsa_pkg.sv */
// ----------------------------------------------------------------------------
// pmsa_pkg
// Shared types and constants for the paddle Morse symbol assembler.
// ----------------------------------------------------------------------------
package pmsa_pkg;

    localparam int CODE_BITS_DEFAULT = 8;

    localparam int DIT_W      = 20;
    localparam int FACTOR_W   = 4;
    localparam int ELAPSED_W  = 16;
    localparam int SINCE_W    = 34;
    localparam int CODE_W     = 8;
    localparam int WORD_LIM_W = 25;
    localparam int FAC_MUL_W  = 14;

    localparam int WORD_DITS  = 20;
    localparam int IDLE_MULT  = 600;

    localparam logic [DIT_W-1:0]    DIT_TIME_RESET   = DIT_W'(60000);
    localparam logic [FACTOR_W-1:0] GAP_FACTOR_RESET = FACTOR_W'(7);
    localparam logic [SINCE_W-1:0]  SINCE_MAX        = {SINCE_W{1'b1}};

    // Register indexes on the configuration channel.
    localparam logic CFG_DIT_TIME   = 1'b0;
    localparam logic CFG_GAP_FACTOR = 1'b1;

    typedef enum logic [1:0] {
        TOK_NONE   = 2'd0,
        TOK_SYMBOL = 2'd1,
        TOK_PAUSE  = 2'd2
    } token_kind_t;

    // Precomputed time limits handed from the configuration block.
    typedef struct packed {
        logic [WORD_LIM_W-1:0] word_limit;
        logic [SINCE_W-1:0]    idle_limit;
    } pmsa_limits_t;

endpackage

/* hdl/pmsa_cfg.sv */
// ----------------------------------------------------------------------------
// pmsa_cfg
// Configuration registers and the symbol-gap and idle limits derived from them.
// ----------------------------------------------------------------------------
module pmsa_cfg
    import pmsa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [DIT_W-1:0]   cfg_data,
    output pmsa_limits_t       limits
);

    logic [DIT_W-1:0]      dit_time_reg;
    logic [FAC_MUL_W-1:0]  fac_mul_reg;
    logic [WORD_LIM_W-1:0] word_limit_reg;
    logic [SINCE_W-1:0]    idle_limit_reg;

    logic                  wr;
    logic [FAC_MUL_W-1:0]  mul_a;
    logic [DIT_W-1:0]      mul_b;
    logic [SINCE_W-1:0]    idle_next;
    logic [FAC_MUL_W-1:0]  fac_mul_next;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    // One shared multiplier: the new register value times the other, held one.
    assign fac_mul_next = FAC_MUL_W'(IDLE_MULT) * FAC_MUL_W'(cfg_data[FACTOR_W-1:0]);

    always_comb
    begin
        unique case (cfg_index)
            CFG_DIT_TIME:
            begin
                mul_a = fac_mul_reg;
                mul_b = cfg_data;
            end
            CFG_GAP_FACTOR:
            begin
                mul_a = fac_mul_next;
                mul_b = dit_time_reg;
            end
            default:
            begin
                mul_a = fac_mul_reg;
                mul_b = dit_time_reg;
            end
        endcase
        idle_next = SINCE_W'(mul_a) * SINCE_W'(mul_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dit_time_reg   <= DIT_TIME_RESET;
            fac_mul_reg    <= FAC_MUL_W'(IDLE_MULT) * FAC_MUL_W'(GAP_FACTOR_RESET);
            word_limit_reg <= WORD_LIM_W'(WORD_DITS) * WORD_LIM_W'(DIT_TIME_RESET);
            idle_limit_reg <= SINCE_W'(IDLE_MULT) * SINCE_W'(GAP_FACTOR_RESET)
                              * SINCE_W'(DIT_TIME_RESET);
        end
        else if (wr)
        begin
            idle_limit_reg <= idle_next;
            if (cfg_index == CFG_DIT_TIME)
            begin
                dit_time_reg   <= cfg_data;
                word_limit_reg <= WORD_LIM_W'(WORD_DITS) * WORD_LIM_W'(cfg_data);
            end
            else
            begin
                fac_mul_reg <= fac_mul_next;
            end
        end
    end

    assign limits.word_limit = word_limit_reg;
    assign limits.idle_limit = idle_limit_reg;

endmodule

/* hdl/paddle_morse_symbol_assembler.sv */
// ----------------------------------------------------------------------------
// paddle_morse_symbol_assembler
// Builds Morse symbol codes from polls of a dit and a dah touch paddle.
// ----------------------------------------------------------------------------
// Each input word is one paddle poll and yields exactly one result word. The
// whole update (time counter, element shift register, limit compares and code
// packing) is done combinationally between the accepted poll and the result
// register, so a poll can be taken every clock unless the output stalls, and
// its result is on the output in the next cycle. A new poll is taken while the
// output is empty or being drained in the same cycle. A configuration write
// updates the limits through one 14x20 multiplier and takes effect for polls
// accepted from the next cycle on.
module paddle_morse_symbol_assembler
    import pmsa_pkg::*;
#(
    parameter int CODE_BITS = CODE_BITS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [23:0]        s_tdata,   // dit_touch, dah_touch, elapsed_us[15:0], zero pad
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,   // symbol_code[7:0], overflow_error, tone_dit,
                                          // tone_dah, idle_flag, zero pad
    output logic [1:0]         m_tuser,   // token_kind
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [DIT_W-1:0]   cfg_data
);

    localparam int SH_W  = CODE_BITS + 1;
    localparam int CNT_W = $clog2(CODE_BITS + 2);
    localparam logic [SH_W-1:0] SH_EMPTY = SH_W'(1);

    pmsa_limits_t limits;

    pmsa_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .limits    (limits)
    );

    logic [SINCE_W-1:0] since_reg, since_next;
    logic [SH_W-1:0]    shift_reg, shift_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic               out_valid_reg;
    token_kind_t        kind_reg, kind_next;
    logic [CODE_W-1:0]  code_reg, code_next;
    logic               ovf_reg, ovf_next;
    logic               tdit_reg, tdit_next;
    logic               tdah_reg, tdah_next;
    logic               idle_reg, idle_next;

    logic                 in_acc;
    logic                 dit_in;
    logic                 dah_in;
    logic [ELAPSED_W-1:0] elapsed_in;
    logic [SINCE_W:0]     sum;
    logic [15:0]          sh_ext;
    logic [2:0]           n3;
    logic [7:0]           elems;
    logic [8:0]           code_ext;

    assign dit_in     = s_tdata[0];
    assign dah_in     = s_tdata[1];
    assign elapsed_in = s_tdata[17:2];

    assign s_tready = !out_valid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;

    always_comb
    begin
        sum        = {1'b0, since_reg} + (SINCE_W + 1)'(elapsed_in);
        since_next = sum[SINCE_W] ? SINCE_MAX : sum[SINCE_W-1:0];
        shift_next = shift_reg;
        count_next = count_reg;
        kind_next  = TOK_NONE;
        code_next  = '0;
        ovf_next   = 1'b0;
        tdit_next  = 1'b0;
        tdah_next  = 1'b0;

        if (dit_in || dah_in)
        begin
            since_next = '0;
            count_next = count_next + CNT_W'(1);
        end

        case ({dit_in, dah_in})
            2'b10:
            begin
                tdit_next  = 1'b1;
                shift_next = shift_next << 1;
            end
            2'b01:
            begin
                tdah_next  = 1'b1;
                shift_next = {shift_next[SH_W-2:0], 1'b1};
            end
            2'b11:
            begin
                // Squeeze: a dit goes first after a dah or with nothing pending.
                if (shift_next[0])
                begin
                    tdit_next  = 1'b1;
                    shift_next = shift_next << 1;
                    count_next = count_next + CNT_W'(1);
                end
                tdah_next  = 1'b1;
                shift_next = {shift_next[SH_W-2:0], 1'b1};
            end
            default:
            begin
            end
        endcase

        if (count_next >= CNT_W'(CODE_BITS))
        begin
            ovf_next   = 1'b1;
            count_next = '0;
            shift_next = SH_EMPTY;
            since_next = '0;
        end

        // Left-justify the pending elements and append the end marker.
        sh_ext   = 16'(shift_next);
        n3       = 3'(count_next);
        elems    = sh_ext[7:0] & 8'((9'd1 << n3) - 9'd1);
        code_ext = {elems, 1'b1} << (3'd7 - n3);

        if (SINCE_W'(limits.word_limit) < since_next)
        begin
            if (shift_next != SH_EMPTY)
            begin
                kind_next  = TOK_SYMBOL;
                code_next  = code_ext[7:0];
                count_next = '0;
                shift_next = SH_EMPTY;
            end
            else if (count_next == '0)
            begin
                kind_next = TOK_PAUSE;
            end
        end

        idle_next = (shift_next == SH_EMPTY) && (limits.idle_limit < since_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            since_reg     <= '0;
            shift_reg     <= SH_EMPTY;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                since_reg     <= since_next;
                shift_reg     <= shift_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            kind_reg <= kind_next;
            code_reg <= code_next;
            ovf_reg  <= ovf_next;
            tdit_reg <= tdit_next;
            tdah_reg <= tdah_next;
            idle_reg <= idle_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {4'b0000, idle_reg, tdah_reg, tdit_reg, ovf_reg, code_reg};

`ifndef SYNTH
    // An empty shift register and a zero element count always go together.
    a_empty_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        (shift_reg == SH_EMPTY) == (count_reg == '0))
        else $error("element shift register and count disagree");

    a_count_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CNT_W'(CODE_BITS))
        else $error("element count reached CODE_BITS");

    a_overflow_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && ovf_next) |=> (shift_reg == SH_EMPTY && since_reg == '0))
        else $error("overflow did not clear the symbol state");

    a_symbol_has_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == TOK_SYMBOL) |-> (m_tdata[7:0] != 8'd0))
        else $error("symbol word without an end marker");

    a_tone_no_token: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[9] || m_tdata[10])) |-> (m_tuser == TOK_NONE))
        else $error("token reported on a touched poll");
`endif

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the paddle Morse symbol assembler. A queue of paddle
// polls feeds a clocked driver; every accepted poll runs through a local model
// of the keyer, and a clocked monitor compares each output word against the
// oldest predicted token. Traffic covers directed corner cases, symbol-shaped
// random sequences under several limit settings, and a short run at the
// largest limits.
// ----------------------------------------------------------------------------
module tb_top;
    import pmsa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CODE_BITS = CODE_BITS_DEFAULT;

    typedef struct {
        logic                 dit;
        logic                 dah;
        logic [ELAPSED_W-1:0] elapsed_us;
    } poll_t;

    typedef struct {
        token_kind_t       kind;
        logic [CODE_W-1:0] code;
        logic              overflow;
        logic              tone_dit;
        logic              tone_dah;
        logic              idle;
    } token_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [23:0]       s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [15:0]       m_tdata;
    logic [1:0]        m_tuser;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_index = CFG_DIT_TIME;
    logic [DIT_W-1:0]  cfg_data = '0;

    // Keyer model state and its copy of the configuration registers.
    logic [DIT_W-1:0]    dit_us_cfg     = DIT_TIME_RESET;
    logic [FACTOR_W-1:0] gap_factor_cfg = GAP_FACTOR_RESET;
    logic [SINCE_W-1:0]  quiet_us       = '0;
    int unsigned         elem_sr        = 1;
    int unsigned         elem_cnt       = 0;

    poll_t  poll_q[$];
    token_t token_q[$];
    poll_t  next_poll;
    token_t want;

    int  polls_queued = 0;
    int  bad_words = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    bit  gap_on = 1'b1;
    bit  hold_arm = 1'b0;
    bit  hold_used = 1'b0;

    paddle_morse_symbol_assembler #(
        .CODE_BITS (CODE_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // One poll of the keyer: returns the token it yields and advances the state.
    function automatic token_t key_poll(logic dit, logic dah, logic [ELAPSED_W-1:0] el);
        token_t          t;
        logic [SINCE_W:0] sum;
        logic [63:0]     word_lim;
        logic [63:0]     idle_lim;
        int unsigned     n;
        int unsigned     packed_code;
        t.kind = TOK_NONE;
        t.code = '0;
        t.overflow = 1'b0;
        t.tone_dit = 1'b0;
        t.tone_dah = 1'b0;
        word_lim = 64'(WORD_DITS) * 64'(dit_us_cfg);
        idle_lim = 64'(IDLE_MULT) * 64'(gap_factor_cfg) * 64'(dit_us_cfg);

        sum = {1'b0, quiet_us} + (SINCE_W + 1)'(el);
        quiet_us = sum[SINCE_W] ? SINCE_MAX : sum[SINCE_W-1:0];

        if (dit || dah)
        begin
            quiet_us = '0;
            elem_cnt++;
        end
        if (dit && !dah)
        begin
            t.tone_dit = 1'b1;
            elem_sr = elem_sr << 1;
        end
        else if (!dit && dah)
        begin
            t.tone_dah = 1'b1;
            elem_sr = (elem_sr << 1) | 1;
        end
        else if (dit && dah)
        begin
            // Squeeze keying: a dit goes first unless the last element was a dit.
            if (elem_sr[0])
            begin
                t.tone_dit = 1'b1;
                elem_sr = elem_sr << 1;
                elem_cnt++;
            end
            t.tone_dah = 1'b1;
            elem_sr = (elem_sr << 1) | 1;
        end

        if (elem_cnt >= CODE_BITS)
        begin
            t.overflow = 1'b1;
            elem_cnt = 0;
            elem_sr = 1;
            quiet_us = '0;
        end

        if (64'(quiet_us) > word_lim)
        begin
            if (elem_sr != 1)
            begin
                n = elem_cnt & 7;
                packed_code = (((elem_sr & ((1 << n) - 1)) << 1) | 1) << (7 - n);
                t.kind = TOK_SYMBOL;
                t.code = packed_code[7:0];
                elem_cnt = 0;
                elem_sr = 1;
            end
            else if (elem_cnt == 0)
            begin
                t.kind = TOK_PAUSE;
            end
        end

        t.idle = (elem_sr == 1) && (64'(quiet_us) > idle_lim);
        return t;
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Poll driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
                token_q.push_back(key_poll(s_tdata[0], s_tdata[1], s_tdata[17:2]));
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (poll_q.size() > 0)
            begin
                next_poll = poll_q.pop_front();
                s_tdata <= {6'b0, next_poll.elapsed_us, next_poll.dah, next_poll.dit};
                s_tvalid <= 1'b1;
                gap_left <= gap_on ? draw_gap() : 0;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Token monitor and scoreboard.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (token_q.size() == 0)
                begin
                    if (bad_words < 10)
                        $display("unexpected word: kind %0d data %h", m_tuser, m_tdata);
                    bad_words++;
                end
                else
                begin
                    want = token_q.pop_front();
                    if (m_tuser !== want.kind || m_tdata[7:0] !== want.code
                        || m_tdata[8] !== want.overflow || m_tdata[9] !== want.tone_dit
                        || m_tdata[10] !== want.tone_dah || m_tdata[11] !== want.idle)
                    begin
                        if (bad_words < 10)
                            $display({"word mismatch: exp kind %0d code %h ovf %b dit %b dah %b",
                                      " idle %b / got kind %0d code %h ovf %b dit %b dah %b",
                                      " idle %b"},
                                     want.kind, want.code, want.overflow, want.tone_dit,
                                     want.tone_dah, want.idle, m_tuser, m_tdata[7:0],
                                     m_tdata[8], m_tdata[9], m_tdata[10], m_tdata[11]);
                        bad_words++;
                    end
                end
            end

            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end
            else if (hold_arm && !hold_used)
            begin
                // Long hold-off so the output register fills and the input stalls.
                hold_used <= 1'b1;
                hold_left <= 300;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                m_tready <= 1'b0;
            end
            else if (gap_on && $urandom_range(0, 2) == 0)
            begin
                stall_left <= draw_gap();
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic queue_poll(bit dit, bit dah, int unsigned el);
        poll_q.push_back('{dit, dah, ELAPSED_W'(el)});
        polls_queued++;
    endtask

    task automatic write_reg(logic idx, logic [DIT_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_DIT_TIME)
            dit_us_cfg = val;
        else
            gap_factor_cfg = val[FACTOR_W-1:0];
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (poll_q.size() != 0 || s_tvalid || token_q.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    // Mostly whole symbols followed by enough quiet time to release them,
    // with overflow bursts and loose polls mixed in.
    task automatic gen_traffic(int n_polls);
        longint unsigned lim;
        longint unsigned acc;
        int              start;
        int              len;
        int              kind;
        int              r;
        start = polls_queued;
        lim = 64'(WORD_DITS) * 64'(dit_us_cfg);
        while (polls_queued - start < n_polls)
        begin
            r = $urandom_range(0, 99);
            if (r < 85)
            begin
                len = (r < 75) ? $urandom_range(1, 7) : $urandom_range(8, 10);
                repeat (len)
                begin
                    kind = $urandom_range(0, 2);
                    queue_poll(kind != 1, kind != 0, $urandom_range(0, 65535));
                end
                acc = 0;
                while (acc <= lim)
                begin
                    r = $urandom_range(32768, 65535);
                    acc += r;
                    queue_poll(1'b0, 1'b0, r);
                end
                repeat ($urandom_range(0, 3))
                    queue_poll(1'b0, 1'b0, $urandom_range(0, 65535));
            end
            else
            begin
                queue_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           $urandom_range(0, 65535));
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Limits as they come out of reset.
        gen_traffic(100);
        wait_drained();

        write_reg(CFG_DIT_TIME, DIT_W'(1000));
        write_reg(CFG_GAP_FACTOR, DIT_W'(1));

        // Directed: word limit is 20000 us here.
        queue_poll(1'b0, 1'b0, 0);
        queue_poll(1'b0, 1'b0, 65535);     // nothing pending: pause
        queue_poll(1'b1, 1'b0, 65535);     // touch clears the time just added
        queue_poll(1'b0, 1'b0, 30000);     // releases a lone dit
        queue_poll(1'b0, 1'b1, 100);
        queue_poll(1'b1, 1'b1, 0);         // after a dah: dit then dah
        queue_poll(1'b0, 1'b0, 65535);
        queue_poll(1'b1, 1'b1, 5);         // nothing pending: dit then dah
        queue_poll(1'b0, 1'b0, 20001);
        queue_poll(1'b1, 1'b0, 7);
        queue_poll(1'b1, 1'b1, 9);         // after a dit: dah only
        queue_poll(1'b0, 1'b0, 20000);     // exactly at the limit, still pending
        queue_poll(1'b0, 1'b0, 1);
        repeat (6)
            queue_poll(1'b0, 1'b1, 300);
        queue_poll(1'b1, 1'b1, 300);       // squeeze brings the count up to CODE_BITS
        queue_poll(1'b0, 1'b0, 65535);
        wait_drained();

        gap_on = 1'b0;
        gen_traffic(250);
        wait_drained();

        gap_on = 1'b1;
        write_reg(CFG_GAP_FACTOR, DIT_W'(15));
        hold_arm = 1'b1;
        gen_traffic(250);
        wait_drained();

        write_reg(CFG_DIT_TIME, DIT_W'($urandom_range(1000, 3276)));
        write_reg(CFG_GAP_FACTOR, DIT_W'($urandom_range(1, 15)));
        gen_traffic(250);
        wait_drained();

        write_reg(CFG_DIT_TIME, DIT_W'($urandom_range(20000, 100000)));
        write_reg(CFG_GAP_FACTOR, DIT_W'($urandom_range(1, 15)));
        gen_traffic(150);
        wait_drained();

        // Largest limits; the symbol stays pending through a short quiet run.
        gap_on = 1'b0;
        write_reg(CFG_DIT_TIME, {DIT_W{1'b1}});
        write_reg(CFG_GAP_FACTOR, DIT_W'(15));
        queue_poll(1'b0, 1'b1, 0);
        queue_poll(1'b1, 1'b0, 0);
        queue_poll(1'b1, 1'b1, 0);
        repeat (40)
            queue_poll(1'b0, 1'b0, 65535);
        queue_poll(1'b1, 1'b0, 65535);
        queue_poll(1'b0, 1'b0, 65535);
        wait_drained();

        repeat (10) @(posedge clk);
        if (bad_words == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
hdl/pmsa_pkg.sv
hdl/pmsa_cfg.sv
hdl/paddle_morse_symbol_assembler.sv
bench/tb_top.sv
